// ===== sv/double_hash_table_unit_macros.svh =====
// Assertion macros for the double hash table unit checker.
// Included by the checker file only; no other dependencies.
`ifndef DOUBLE_HASH_TABLE_UNIT_MACROS_SVH
`define DOUBLE_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define DHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double hash table check failed");

// next-cycle implication, held off during reset
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double hash table check failed");

`endif

// ===== sv/dht_pkg.sv =====
// Shared types, codes and hash helpers for the double hash table unit.
// No dependencies; the files that use it refer to it by scoped names.
package dht_pkg;

  localparam int OPCODE_W   = 2;
  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int MARK_W     = 2;
  localparam int NSUM_W     = 7;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic load;
    logic hash;
    logic seed;
    logic probe;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } dp_stat_t;

  // 16 == 1 mod 5, so the nibble sum keeps the key's residue mod 5
  function automatic logic [NSUM_W-1:0] nibble_sum(input logic [KEY_W-1:0] key);
    logic [KEY_W:0]      k;
    logic [NSUM_W-1:0]   s;
    k = {1'b0, key};
    s = '0;
    for (int i = 0; i < (KEY_W + 1) / 4; i++) begin
      s = s + NSUM_W'(k[i*4 +: 4]);
    end
    return s;
  endfunction

  function automatic logic [2:0] mod5_small(input logic [NSUM_W-1:0] s);
    logic [4:0] t;
    t = 5'(s[NSUM_W-1:4]) + 5'(s[3:0]);
    if (t >= 5'd20) t = t - 5'd20;
    if (t >= 5'd10) t = t - 5'd10;
    if (t >= 5'd5)  t = t - 5'd5;
    return t[2:0];
  endfunction

endpackage

// ===== sv/dht_if.sv =====
// Request and result channel interfaces of the double hash table unit.
// Depends on dht_pkg for field widths.
interface dht_in_if;
  logic                          valid;
  logic                          ready;
  logic [dht_pkg::OPCODE_W-1:0]  opcode;
  logic [dht_pkg::KEY_W-1:0]     key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface dht_out_if;
  logic                            valid;
  logic                            ready;
  logic [dht_pkg::STATUS_W-1:0]    status;
  logic [dht_pkg::SLOT_IDX_W-1:0]  slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// ===== sv/double_hash_table_unit.sv =====
// Top level of the double hash table unit: controller plus datapath.
// Depends on dht_pkg, dht_in_if/dht_out_if, dht_ctrl and dht_datapath.
//
// Open-addressing hash table of TABLE_SIZE slots with double hashing: home
// slot key mod 10, step 3 + key mod 5, both reduced mod TABLE_SIZE. Opcodes
// insert, find and delete; every request gives exactly one result with a
// status (done/found, not found, table full) and, on success, the slot it
// touched (zero otherwise). The unit works on one request at a time. A
// request accepted in idle is latched, hashed and seeded, then walks p
// probes (p is 1 to TABLE_SIZE), and its result is emitted once the output
// register is free; the walk does one probe per cycle through the key RAM,
// whose registered read is fetched one probe ahead. The next request is
// taken as soon as the result sits in the output register. Slot marks
// reset to empty at once; there is no clearing pass.
module double_hash_table_unit #(
  parameter int TABLE_SIZE = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  dht_in_if.sink     in_ch,
  dht_out_if.source  out_ch
);

  dht_pkg::ctrl_cmd_t cmd;
  dht_pkg::dp_stat_t  stat;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  dht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_ch.opcode),
    .in_key         (in_ch.key),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_slot_index (out_ch.slot_index)
  );

endmodule

// ===== sv/dht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dht_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dht_ctrl.sv =====
// Sequencer of the double hash table unit: accept, hash, seed, probe walk, emit.
// Depends on dht_pkg for the command and status structs.
module dht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output dht_pkg::ctrl_cmd_t  cmd,
  input  dht_pkg::dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_SEED  = 5'b00100,
    S_PROBE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/dht_datapath.sv =====
// Datapath of the double hash table unit: hashing, probe walk, slot marks,
// key RAM and result register. Depends on dht_pkg and dht_ram.
module dht_datapath #(
  parameter int TABLE_SIZE = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dht_pkg::ctrl_cmd_t                cmd,
  output dht_pkg::dp_stat_t                 stat,
  input  logic [dht_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [dht_pkg::KEY_W-1:0]         in_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dht_pkg::STATUS_W-1:0]      out_status,
  output logic [dht_pkg::SLOT_IDX_W-1:0]    out_slot_index
);

  localparam int SW = $clog2(TABLE_SIZE);
  localparam int AW = SW + 1;
  localparam logic [AW-1:0] SIZE_A = AW'(TABLE_SIZE);
  localparam logic [SW-1:0] LAST_PROBE = SW'(TABLE_SIZE - 1);

  logic [dht_pkg::OPCODE_W-1:0]   op_r;
  logic [dht_pkg::KEY_W-1:0]      key_r;
  logic [dht_pkg::NSUM_W-1:0]     sum_r;
  logic [SW-1:0]                  step_r;
  logic [SW-1:0]                  cur_slot_r;
  logic [SW-1:0]                  cnt_r;
  logic [dht_pkg::MARK_W-1:0]     mark_q_r;
  logic [dht_pkg::MARK_W-1:0]     marks_r [TABLE_SIZE];
  logic [dht_pkg::STATUS_W-1:0]   res_status_r;
  logic [SW-1:0]                  res_slot_r;
  logic                           out_valid_r;
  logic [dht_pkg::STATUS_W-1:0]   out_status_r;
  logic [dht_pkg::SLOT_IDX_W-1:0] out_slot_r;

  logic [dht_pkg::KEY_W-1:0]      key_q;
  logic [2:0]                     r5;
  logic [3:0]                     h1, h2;
  logic [AW-1:0]                  h1_a, h2_a, next_a;
  logic [SW-1:0]                  slot0, step0, next_slot, rd_slot;
  logic                           done;
  logic [dht_pkg::STATUS_W-1:0]   dec_status;
  logic                           key_we, mark_we;
  logic [dht_pkg::MARK_W-1:0]     mark_wval;
  logic                           key_hit;

  // home slot and step from the key residue mod 5 and the key's parity
  assign r5     = dht_pkg::mod5_small(sum_r);
  assign h1     = (r5[0] == key_r[0]) ? {1'b0, r5} : {1'b0, r5} + 4'd5;
  assign h2     = 4'd3 + {1'b0, r5};
  assign h1_a   = AW'(h1);
  assign h2_a   = AW'(h2);
  assign slot0  = (h1_a >= SIZE_A) ? SW'(h1_a - SIZE_A) : SW'(h1_a);
  assign step0  = (h2_a >= SIZE_A) ? SW'(h2_a - SIZE_A) : SW'(h2_a);

  assign next_a    = {1'b0, cur_slot_r} + {1'b0, step_r};
  assign next_slot = (next_a >= SIZE_A) ? SW'(next_a - SIZE_A) : SW'(next_a);
  // fetch the next probe ahead of the decision; drop it if the walk stops
  assign rd_slot   = cmd.seed ? slot0 : next_slot;

  dht_ram #(
    .WIDTH (dht_pkg::KEY_W),
    .DEPTH (TABLE_SIZE)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (cur_slot_r),
    .wdata (key_r),
    .raddr (rd_slot),
    .rdata (key_q)
  );

  assign key_hit = (mark_q_r == dht_pkg::MARK_USED) && (key_q == key_r);

  always_comb begin
    done       = 1'b0;
    dec_status = dht_pkg::ST_MISSING;
    mark_wval  = dht_pkg::MARK_USED;
    mark_we    = 1'b0;
    key_we     = 1'b0;
    case (op_r)
      dht_pkg::OP_INSERT: begin
        if (mark_q_r != dht_pkg::MARK_USED) begin
          done       = 1'b1;
          dec_status = dht_pkg::ST_OK;
          mark_we    = 1'b1;
          key_we     = 1'b1;
        end else if (cnt_r == LAST_PROBE) begin
          done       = 1'b1;
          dec_status = dht_pkg::ST_FULL;
        end
      end
      dht_pkg::OP_FIND, dht_pkg::OP_DELETE: begin
        if (mark_q_r == dht_pkg::MARK_EMPTY) begin
          done = 1'b1;
        end else if (key_hit) begin
          done       = 1'b1;
          dec_status = dht_pkg::ST_OK;
          mark_wval  = dht_pkg::MARK_GONE;
          mark_we    = (op_r == dht_pkg::OP_DELETE);
        end else if (cnt_r == LAST_PROBE) begin
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
    if (!cmd.probe) begin
      mark_we = 1'b0;
      key_we  = 1'b0;
    end
  end

  assign stat.done     = done;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= in_key;
    end
    if (cmd.hash) begin
      sum_r <= dht_pkg::nibble_sum(key_r);
    end
    if (cmd.seed) begin
      step_r <= step0;
      cnt_r  <= '0;
    end else if (cmd.probe) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.seed || cmd.probe) begin
      cur_slot_r <= rd_slot;
      mark_q_r   <= marks_r[rd_slot];
    end
    if (cmd.probe && done) begin
      res_status_r <= dec_status;
      res_slot_r   <= (dec_status == dht_pkg::ST_OK) ? cur_slot_r : '0;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= dht_pkg::SLOT_IDX_W'(res_slot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        marks_r[i] <= dht_pkg::MARK_EMPTY;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (mark_we) begin
        marks_r[cur_slot_r] <= mark_wval;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

endmodule

// ===== sv/dht_checker.sv =====
// Port-level checks for the double hash table unit, bound to the top level.
// Depends on dht_pkg and double_hash_table_unit_macros.svh.
`include "double_hash_table_unit_macros.svh"

module dht_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dht_pkg::STATUS_W-1:0]      status,
  input logic [dht_pkg::SLOT_IDX_W-1:0]    slot_index
);

  `DHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_index))
  `DHT_ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready)
  `DHT_ASSERT_NOW(a_slot_zero, clk, rst_n, out_valid && status != dht_pkg::ST_OK, slot_index == '0)
  `DHT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, status == dht_pkg::ST_OK || status == dht_pkg::ST_MISSING || status == dht_pkg::ST_FULL)

endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .slot_index (out_ch.slot_index)
);
